>>> rtl/core/fit_policy_block_allocator_top_assert.svh
// Assertion macros for the fit policy block allocator.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FPBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/fpba_pkg.sv
// Package with sizes, codes and sequencer states for the block allocator.
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_WIDTH = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    localparam int IN_SIZE_W  = 16;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_REM_W  = 16;
    localparam int MODE_W     = 2;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } fpba_state_t;

endpackage

`default_nettype wire

>>> rtl/core/fit_policy_block_allocator_top.sv
// Top level of the fit policy block allocator: free space table and scan sequencer.
`timescale 1ns / 1ps
`default_nettype none

// A load word (action 0) writes the next table entry in its accept cycle while
// the table is not full and gives no result; busy stays low. An allocate word
// (action 1) scans the loaded entries through one shared compare unit, one
// entry per cycle, then writes the chosen entry back if one fits: busy stays
// high until then (under the unused policy value the scan is skipped), and the
// result shows for one cycle, marked by done, in the cycle after that.
// The receiver cannot stall: done is high for exactly one cycle, and the result
// fields hold until the next result. Write cfg_data only while busy is low and
// no result is due.

module fit_policy_block_allocator_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               action,
    input  wire logic [fpba_pkg::IN_SIZE_W-1:0]     size,
    output logic                                    done,
    output logic                                    granted,
    output logic [fpba_pkg::OUT_IDX_W-1:0]          block_index,
    output logic [fpba_pkg::OUT_REM_W-1:0]          remaining,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [fpba_pkg::MODE_W-1:0]        cfg_data
);

    fpba_pkg::fpba_state_t state_reg, state_next;

    logic [fpba_pkg::MODE_W-1:0]     mode_reg;
    logic [fpba_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [fpba_pkg::CNT_W-1:0]      scan_reg, scan_next;
    logic                            found_reg, found_next;
    logic [fpba_pkg::IDX_W-1:0]      pick_reg, pick_next;
    logic [fpba_pkg::SIZE_WIDTH-1:0] best_reg, best_next;
    logic [fpba_pkg::SIZE_WIDTH-1:0] req_reg, req_next;

    logic                            done_reg, done_next;
    logic                            granted_reg, granted_next;
    logic [fpba_pkg::OUT_IDX_W-1:0]  index_reg, index_next;
    logic [fpba_pkg::OUT_REM_W-1:0]  remaining_reg, remaining_next;

    logic [fpba_pkg::SIZE_WIDTH-1:0] mem [fpba_pkg::NUM_BLOCKS];
    logic                            mem_we;
    logic [fpba_pkg::IDX_W-1:0]      mem_waddr;
    logic [fpba_pkg::SIZE_WIDTH-1:0] mem_wdata;

    logic [fpba_pkg::SIZE_WIDTH-1:0] avail_reg;
    logic [fpba_pkg::SIZE_WIDTH-1:0] diff;
    logic                            fits;
    logic                            take;
    logic                            accept;

    assign accept    = start && (state_reg == fpba_pkg::ST_IDLE);
    assign busy      = (state_reg != fpba_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == fpba_pkg::ST_IDLE);

    assign done        = done_reg;
    assign granted     = granted_reg;
    assign block_index = index_reg;
    assign remaining   = remaining_reg;

    assign diff  = best_reg - req_reg;
    assign fits  = (avail_reg >= req_reg);
    assign take  = fits && (!found_reg
                         || ((mode_reg == fpba_pkg::MODE_BEST)  && (avail_reg < best_reg))
                         || ((mode_reg == fpba_pkg::MODE_WORST) && (avail_reg > best_reg)));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        avail_reg <= mem[scan_next[fpba_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpba_pkg::ST_IDLE;
            mode_reg  <= fpba_pkg::MODE_FIRST;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg      <= scan_next;
        found_reg     <= found_next;
        pick_reg      <= pick_next;
        best_reg      <= best_next;
        req_reg       <= req_next;
        granted_reg   <= granted_next;
        index_reg     <= index_next;
        remaining_reg <= remaining_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        best_next      = best_reg;
        req_next       = req_reg;
        done_next      = 1'b0;
        granted_next   = granted_reg;
        index_next     = index_reg;
        remaining_next = remaining_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[fpba_pkg::IDX_W-1:0];
        mem_wdata      = fpba_pkg::SIZE_WIDTH'(size);

        unique case (state_reg)
            fpba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == fpba_pkg::ACT_LOAD)
                    begin
                        if (count_reg < fpba_pkg::CNT_W'(fpba_pkg::NUM_BLOCKS))
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        req_next   = fpba_pkg::SIZE_WIDTH'(size);
                        scan_next  = '0;
                        found_next = 1'b0;
                        pick_next  = '0;
                        best_next  = '0;
                        if (mode_reg == fpba_pkg::MODE_FIRST
                            || mode_reg == fpba_pkg::MODE_BEST
                            || mode_reg == fpba_pkg::MODE_WORST)
                        begin
                            state_next = fpba_pkg::ST_SCAN;
                        end
                        else
                        begin
                            state_next = fpba_pkg::ST_FINISH;
                        end
                    end
                end
            end

            fpba_pkg::ST_SCAN:
            begin
                if (scan_reg >= count_reg)
                begin
                    state_next = fpba_pkg::ST_FINISH;
                end
                else
                begin
                    if (take)
                    begin
                        found_next = 1'b1;
                        pick_next  = scan_reg[fpba_pkg::IDX_W-1:0];
                        best_next  = avail_reg;
                    end
                    scan_next = scan_reg + 1'b1;
                end
            end

            fpba_pkg::ST_FINISH:
            begin
                done_next  = 1'b1;
                state_next = fpba_pkg::ST_IDLE;
                if (found_reg)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = pick_reg;
                    mem_wdata      = diff;
                    granted_next   = 1'b1;
                    index_next     = fpba_pkg::OUT_IDX_W'(pick_reg);
                    remaining_next = fpba_pkg::OUT_REM_W'(diff);
                end
                else
                begin
                    granted_next   = 1'b0;
                    index_next     = '0;
                    remaining_next = '0;
                end
            end

            default:
            begin
                state_next = fpba_pkg::ST_IDLE;
            end
        endcase
    end

`include "fit_policy_block_allocator_top_assert.svh"

    `FPBA_ASSERT_NEXT(a_finish_strobes, state_reg == fpba_pkg::ST_FINISH, done_reg, "finish gave no result strobe")
    `FPBA_ASSERT_NEXT(a_strobe_single, done_reg, !done_reg, "result strobe held past one cycle")
    `FPBA_ASSERT_IMP(a_denied_zero, done_reg && !granted_reg, index_reg == '0 && remaining_reg == '0, "denied result carries nonzero fields")
    `FPBA_ASSERT_IMP(a_pick_loaded, done_reg && granted_reg, fpba_pkg::CNT_W'(pick_reg) < count_reg, "granted block lies past the loaded entries")
    `FPBA_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= fpba_pkg::CNT_W'(fpba_pkg::NUM_BLOCKS), "loaded count past capacity")

endmodule

`default_nettype wire

>>> dv/tb_fit_policy_block_allocator_top.sv
// Self-checking testbench for the fit policy block allocator: directed table, then random words.
`timescale 1ns / 1ps

module tb_fit_policy_block_allocator_top;

    localparam logic [fpba_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int END_CYCLES   = 25;
    localparam int N_DIRECTED   = 15;
    localparam int PHASE_WORDS  = 215;

    typedef struct packed {
        logic                           granted;
        logic [fpba_pkg::OUT_IDX_W-1:0] idx;
        logic [fpba_pkg::OUT_REM_W-1:0] rem;
    } alloc_result_t;

    typedef struct packed {
        logic [fpba_pkg::MODE_W-1:0]    mode;
        logic                           act;
        logic [fpba_pkg::IN_SIZE_W-1:0] sz;
        logic                           pinned;
        alloc_result_t                  res;
    } dir_row_t;

    localparam alloc_result_t NO_GRANT = '{1'b0, 4'd0, 16'd0};

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic                             action;
    logic [fpba_pkg::IN_SIZE_W-1:0]   size;
    logic                             done;
    logic                             granted;
    logic [fpba_pkg::OUT_IDX_W-1:0]   block_index;
    logic [fpba_pkg::OUT_REM_W-1:0]   remaining;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [fpba_pkg::MODE_W-1:0]      cfg_data;

    logic [fpba_pkg::SIZE_WIDTH-1:0]  blk_free [fpba_pkg::NUM_BLOCKS] = '{default: '0};
    int                               blk_count = 0;
    logic [fpba_pkg::MODE_W-1:0]      fit_mode_q = fpba_pkg::MODE_FIRST;
    alloc_result_t                    expected_grants [$];
    int                               mismatch_count = 0;
    int                               stall_cycles = 0;
    bit                               pin_valid;
    alloc_result_t                    pin_res;

    dir_row_t directed_rows [N_DIRECTED] = '{
        '{fpba_pkg::MODE_FIRST, fpba_pkg::ACT_ALLOC, 16'd0,     1'b1, NO_GRANT},
        '{fpba_pkg::MODE_FIRST, fpba_pkg::ACT_ALLOC, 16'd65535, 1'b1, NO_GRANT},
        '{fpba_pkg::MODE_FIRST, fpba_pkg::ACT_LOAD,  16'd65535, 1'b0, NO_GRANT},
        '{fpba_pkg::MODE_FIRST, fpba_pkg::ACT_LOAD,  16'd0,     1'b0, NO_GRANT},
        '{fpba_pkg::MODE_FIRST, fpba_pkg::ACT_LOAD,  16'd1000,  1'b0, NO_GRANT},
        '{fpba_pkg::MODE_FIRST, fpba_pkg::ACT_LOAD,  16'd1000,  1'b0, NO_GRANT},
        '{fpba_pkg::MODE_FIRST, fpba_pkg::ACT_ALLOC, 16'd1000,  1'b1, '{1'b1, 4'd0, 16'd64535}},
        '{fpba_pkg::MODE_FIRST, fpba_pkg::ACT_ALLOC, 16'd0,     1'b0, NO_GRANT},
        '{fpba_pkg::MODE_BEST,  fpba_pkg::ACT_ALLOC, 16'd500,   1'b0, NO_GRANT},
        '{fpba_pkg::MODE_BEST,  fpba_pkg::ACT_ALLOC, 16'd0,     1'b0, NO_GRANT},
        '{fpba_pkg::MODE_WORST, fpba_pkg::ACT_ALLOC, 16'd1,     1'b0, NO_GRANT},
        '{fpba_pkg::MODE_WORST, fpba_pkg::ACT_ALLOC, 16'd65535, 1'b1, NO_GRANT},
        '{MODE_UNUSED,          fpba_pkg::ACT_ALLOC, 16'd0,     1'b1, NO_GRANT},
        '{MODE_UNUSED,          fpba_pkg::ACT_LOAD,  16'd7,     1'b0, NO_GRANT},
        '{fpba_pkg::MODE_FIRST, fpba_pkg::ACT_ALLOC, 16'd7,     1'b0, NO_GRANT}
    };

    fit_policy_block_allocator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .size        (size),
        .done        (done),
        .granted     (granted),
        .block_index (block_index),
        .remaining   (remaining),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic predict_placement(input logic act,
                                     input logic [fpba_pkg::IN_SIZE_W-1:0] sz,
                                     output bit has_res, output alloc_result_t r);
        int pick;
        int j;
        has_res = 1'b0;
        r       = NO_GRANT;
        if (act == fpba_pkg::ACT_LOAD)
        begin
            if (blk_count < fpba_pkg::NUM_BLOCKS)
            begin
                blk_free[blk_count] = sz;
                blk_count++;
            end
        end
        else
        begin
            has_res = 1'b1;
            pick    = -1;
            if (fit_mode_q <= fpba_pkg::MODE_WORST)
            begin
                for (j = 0; j < blk_count; j++)
                begin
                    if (blk_free[j] >= sz)
                    begin
                        if (pick < 0)
                        begin
                            pick = j;
                            if (fit_mode_q == fpba_pkg::MODE_FIRST)
                                break;
                        end
                        else if (fit_mode_q == fpba_pkg::MODE_BEST
                                 && blk_free[j] < blk_free[pick])
                            pick = j;
                        else if (fit_mode_q == fpba_pkg::MODE_WORST
                                 && blk_free[j] > blk_free[pick])
                            pick = j;
                    end
                end
            end
            if (pick >= 0)
            begin
                blk_free[pick] = blk_free[pick] - sz;
                r = '{1'b1, pick[fpba_pkg::OUT_IDX_W-1:0], blk_free[pick]};
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input alloc_result_t e,
                                 input alloc_result_t a);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t: %s: expected granted=%0d index=%0d remaining=%0d, ",
                      "got granted=%0d index=%0d remaining=%0d"},
                     $realtime, what, e.granted, e.idx, e.rem, a.granted, a.idx, a.rem);
    endtask

    always @(posedge clk)
    begin : monitor
        alloc_result_t got;
        alloc_result_t want;
        alloc_result_t pred;
        bit            has_res;
        if (rst_n)
        begin
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (done)
            begin
                got = '{granted, block_index, remaining};
                if (expected_grants.size() == 0)
                    flag_mismatch("result with nothing pending", NO_GRANT, got);
                else
                begin
                    want = expected_grants.pop_front();
                    if (got.granted !== want.granted || got.idx !== want.idx
                        || got.rem !== want.rem)
                        flag_mismatch("result mismatch", want, got);
                end
            end
            if (start && !busy)
            begin
                predict_placement(action, size, has_res, pred);
                if (has_res)
                    expected_grants.push_back(pin_valid ? pin_res : pred);
            end
            if (cfg_valid && cfg_ready)
                fit_mode_q = cfg_data;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // call at a falling edge; returns at the edge that takes the word
    task automatic drive_word(input logic act, input logic [fpba_pkg::IN_SIZE_W-1:0] sz,
                              input bit pin, input alloc_result_t pres);
        start     <= 1'b1;
        action    <= act;
        size      <= sz;
        pin_valid  = pin;
        pin_res    = pres;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    task automatic hold_off(input int pct);
        while ($urandom_range(99) < pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_fit_mode(input logic [fpba_pkg::MODE_W-1:0] m);
        drain_results();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int pct, input logic [fpba_pkg::MODE_W-1:0] m,
                              input int n_words);
        logic                           act;
        logic [fpba_pkg::IN_SIZE_W-1:0] sz;
        int                             counted;
        int                             k;
        int                             r;
        set_fit_mode(m);
        counted = 0;
        while (counted < n_words)
        begin
            hold_off(pct);
            @(negedge clk);
            r = $urandom_range(99);
            k = (blk_count > 0) ? $urandom_range(blk_count - 1) : 0;
            act = fpba_pkg::ACT_ALLOC;
            if ((blk_count < fpba_pkg::NUM_BLOCKS && r < 30)
                || (blk_count == fpba_pkg::NUM_BLOCKS && r < 5))
            begin
                act = fpba_pkg::ACT_LOAD;
                r   = $urandom_range(99);
                if (r < 25)
                    sz = 16'hFFFF;
                else if (r < 35)
                    sz = '0;
                else
                    sz = fpba_pkg::IN_SIZE_W'($urandom);
            end
            else
            begin
                r = $urandom_range(99);
                if (blk_count == 0 || r < 8)
                    sz = '0;
                else if (r < 18)
                    sz = fpba_pkg::IN_SIZE_W'($urandom);
                else if (r < 20)
                    sz = blk_free[k];
                else if (r < 26)
                    sz = (blk_free[k] == 16'hFFFF) ? 16'hFFFF : blk_free[k] + 1'b1;
                else if (r < 80)
                    sz = fpba_pkg::IN_SIZE_W'($urandom_range(0, blk_free[k] >> 5));
                else
                    sz = fpba_pkg::IN_SIZE_W'($urandom_range(0, blk_free[k] >> 2));
            end
            if (!(act == fpba_pkg::ACT_LOAD && blk_count >= fpba_pkg::NUM_BLOCKS))
                counted++;
            drive_word(act, sz, 1'b0, NO_GRANT);
        end
    endtask

    initial
    begin : stimulus
        int i;
        rst_n          = 1'b0;
        start          = 1'b0;
        action         = fpba_pkg::ACT_LOAD;
        size           = '0;
        cfg_valid      = 1'b0;
        cfg_data       = fpba_pkg::MODE_FIRST;
        pin_valid      = 1'b0;
        pin_res        = NO_GRANT;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_rows[i].mode != fit_mode_q)
                set_fit_mode(directed_rows[i].mode);
            @(negedge clk);
            drive_word(directed_rows[i].act, directed_rows[i].sz,
                       directed_rows[i].pinned, directed_rows[i].res);
        end

        run_random(6, fpba_pkg::MODE_FIRST, PHASE_WORDS);
        run_random(6, fpba_pkg::MODE_BEST, PHASE_WORDS);
        run_random(6, fpba_pkg::MODE_WORST, PHASE_WORDS);
        run_random(6, MODE_UNUSED, 12);
        run_random(64, fpba_pkg::MODE_WORST, PHASE_WORDS);
        run_random(64, fpba_pkg::MODE_BEST, PHASE_WORDS);
        run_random(64, fpba_pkg::MODE_FIRST, PHASE_WORDS);
        run_random(0, fpba_pkg::MODE_FIRST, PHASE_WORDS);
        run_random(0, fpba_pkg::MODE_WORST, PHASE_WORDS);
        run_random(0, fpba_pkg::MODE_BEST, PHASE_WORDS);

        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_grants.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
